[design/fwrk_pkg.sv]
// Shared types, sizes and token helpers for the keyed-removal token queue.
// Used by fwrk_front, fwrk_back and fifo_with_remove_by_key; no dependencies.
package fwrk_pkg;

    localparam int DEPTH       = 16;
    localparam int TOKEN_BITS  = 16;
    localparam int IDX_BITS    = $clog2(DEPTH);
    localparam int CNT_BITS    = $clog2(DEPTH + 1);
    localparam int CAP_BITS    = 5;
    localparam int OCC_BITS    = 5;
    localparam int PORT_TOKEN_BITS = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_BITS  = 3;
    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(16);

    typedef logic [TOKEN_BITS-1:0] t_tok;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_REM  = 2'd2,
        OP_LIST = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Register index of the configuration space
    localparam logic REG_CAPACITY = 1'b0;

    // Classified request handed from front to back
    typedef struct packed {
        logic enq;
        logic deq;
        logic rem;
        logic lst;
        t_tok key;
    } t_cmd;

    // Fit a port token into the stored token width
    function automatic t_tok tok_from_port(input logic [PORT_TOKEN_BITS-1:0] x);
        logic [63:0] w;
        w = 64'(x);
        return w[TOKEN_BITS-1:0];
    endfunction

    // Fit a stored token onto the result port
    function automatic logic [PORT_TOKEN_BITS-1:0] tok_to_port(input t_tok x);
        logic [63:0] w;
        w = 64'(x);
        return w[PORT_TOKEN_BITS-1:0];
    endfunction

endpackage

[design/fifo_with_remove_by_key.sv]
// Top level of the bounded token queue with removal by key: APB register
// for the capacity, front and back ends. Depends on fwrk_pkg, fwrk_front, fwrk_back.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------------
//  request   | in        | start high, busy low      | i_opcode, i_token
//  result    | out       | o_valid, one cycle, no hold | o_status, o_token_out,
//            |           |                           | o_occupancy, o_last
//  config    | in/out    | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// Enqueue, dequeue and removal pass S_IDLE, which pops the request and registers
// the key match across all slots, then S_EXEC, which updates and compacts slots.
// A list goes on to S_LIST, which streams the stored tokens from the slot file.
// The front queue holds two requests; busy rises only when both are waiting.
// Synchronous active-low reset empties the queue and sets capacity to 16.
// Results cannot be stalled by the receiver; each is shown for one cycle.
module fifo_with_remove_by_key (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_opcode,
    input  logic [fwrk_pkg::PORT_TOKEN_BITS-1:0]  i_token,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output logic [fwrk_pkg::PORT_TOKEN_BITS-1:0]  o_token_out,
    output logic [fwrk_pkg::OCC_BITS-1:0]         o_occupancy,
    output logic                                  o_last,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fwrk_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import fwrk_pkg::*;

    logic [CAP_BITS-1:0] r_capacity;
    t_cmd                cmd;
    logic                cmd_valid;
    logic                cmd_pop;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_CAPACITY);

    // Write the capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_capacity <= pwdata[CAP_BITS-1:0];
        end
    end

    // Read back the capacity register
    assign prdata = reg_sel ? 32'(r_capacity) : '0;

    fwrk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_token     (i_token),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    fwrk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_capacity  (r_capacity),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_token_out (o_token_out),
        .o_occupancy (o_occupancy),
        .o_last      (o_last)
    );

endmodule

[design/fwrk_front.sv]
// Front end: takes requests on the start/busy handshake, decodes the opcode
// and buffers classified requests in a short queue. Depends on fwrk_pkg.
module fwrk_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_opcode,
    input  logic [fwrk_pkg::PORT_TOKEN_BITS-1:0]  i_token,
    output fwrk_pkg::t_cmd                        o_cmd,
    output logic                                  o_cmd_valid,
    input  logic                                  i_cmd_pop
);
    import fwrk_pkg::*;

    t_cmd                  r_q [QUEUE_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_cnt, n_cnt;
    t_cmd                  dec_cmd;
    logic                  push;
    logic                  pop;

    // Classify the incoming request
    always_comb begin
        dec_cmd     = '0;
        dec_cmd.key = tok_from_port(i_token);
        unique case (t_op'(i_opcode))
            OP_ENQ:  dec_cmd.enq = 1'b1;
            OP_DEQ:  dec_cmd.deq = 1'b1;
            OP_REM:  dec_cmd.rem = 1'b1;
            OP_LIST: dec_cmd.lst = 1'b1;
            default: dec_cmd.lst = 1'b1;
        endcase
    end

    assign busy        = (r_cnt == Q_CNT_BITS'(QUEUE_DEPTH));
    assign push        = start && !busy;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Hold the request payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_BITS'(QUEUE_DEPTH))
        else $error("request queue overfilled");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("accepted request not counted");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> $onehot({o_cmd.enq, o_cmd.deq, o_cmd.rem, o_cmd.lst}))
        else $error("queued request has no single kind");

endmodule

[design/fwrk_back.sv]
// Back end: holds the token slots and fill count, carries out enqueue,
// dequeue, keyed removal with compaction and listing. Depends on fwrk_pkg.
module fwrk_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  fwrk_pkg::t_cmd                        i_cmd,
    input  logic                                  i_cmd_valid,
    output logic                                  o_cmd_pop,
    input  logic [fwrk_pkg::CAP_BITS-1:0]         i_capacity,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output logic [fwrk_pkg::PORT_TOKEN_BITS-1:0]  o_token_out,
    output logic [fwrk_pkg::OCC_BITS-1:0]         o_occupancy,
    output logic                                  o_last
);
    import fwrk_pkg::*;

    localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LIST = 3'b100
    } t_state;

    t_tok                         r_slots [DEPTH];
    t_state                       r_state, n_state;
    logic [CNT_BITS-1:0]          r_count, n_count;
    logic [IDX_BITS-1:0]          r_idx, n_idx;
    t_cmd                         r_cmd;
    logic [DEPTH-1:0]             r_hit;
    logic [DEPTH-1:0]             hit;
    logic [DEPTH-1:0]             low_hit;
    logic [DEPTH-1:0]             rem_mask;
    logic [DEPTH-1:0]             shift_mask;
    logic                         wr_en;
    logic                         full;
    logic                         list_last;

    logic                         r_out_valid, n_out_valid;
    t_status                      r_out_status, n_out_status;
    t_tok                         r_out_tok, n_out_tok;
    logic [OCC_BITS-1:0]          r_out_occ, n_out_occ;
    logic                         r_out_last, n_out_last;

    // Compare the key against every held slot
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hit[i] = (CNT_BITS'(i) < r_count) && (r_slots[i] == i_cmd.key);
        end
    end

    // Isolate the first match and mark it and everything behind it
    assign low_hit  = r_hit & (~r_hit + DEPTH'(1));
    assign rem_mask = ~(low_hit - DEPTH'(1));

    assign full = (r_count == CNT_BITS'(DEPTH)) ||
                  (CMP_BITS'(r_count) >= CMP_BITS'(i_capacity));
    assign list_last = ((CNT_BITS'(r_idx) + 1'b1) == r_count);
    assign o_cmd_pop = (r_state == S_IDLE);

    // Sequence one request at a time
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = 1'b0;
        n_out_status = ST_OK;
        n_out_tok    = '0;
        n_out_occ    = OCC_BITS'(r_count);
        n_out_last   = 1'b1;
        shift_mask   = '0;
        wr_en        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                if (r_cmd.enq) begin
                    if (full) begin
                        n_out_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end else if (r_cmd.deq) begin
                    if (r_count == '0) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        shift_mask = '1;
                        n_out_tok  = r_slots[0];
                        n_count    = r_count - 1'b1;
                    end
                end else if (r_cmd.rem) begin
                    if (r_hit == '0) begin
                        n_out_status = ST_NOTFOUND;
                    end else begin
                        shift_mask = rem_mask;
                        n_out_tok  = r_cmd.key;
                        n_count    = r_count - 1'b1;
                    end
                end else begin
                    if (r_count == '0) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        // Hand off to the streaming state
                        n_out_valid = 1'b0;
                        n_idx       = '0;
                        n_state     = S_LIST;
                    end
                end
                n_out_occ = OCC_BITS'(n_count);
            end
            S_LIST: begin
                n_out_valid = 1'b1;
                n_out_tok   = r_slots[r_idx];
                n_out_last  = list_last;
                n_idx       = r_idx + 1'b1;
                if (list_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture request, match vector and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
            r_hit <= hit;
        end
        r_idx        <= n_idx;
        r_out_status <= n_out_status;
        r_out_tok    <= n_out_tok;
        r_out_occ    <= n_out_occ;
        r_out_last   <= n_out_last;
    end

    // Shift slots forward for compaction, or write at the rear
    for (genvar g = 0; g < DEPTH; g++) begin : g_slot
        if (g < DEPTH - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (shift_mask[g]) begin
                    r_slots[g] <= r_slots[g+1];
                end else if (wr_en && r_count[IDX_BITS-1:0] == IDX_BITS'(g)) begin
                    r_slots[g] <= r_cmd.key;
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (wr_en && r_count[IDX_BITS-1:0] == IDX_BITS'(g)) begin
                    r_slots[g] <= r_cmd.key;
                end
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_token_out = tok_to_port(r_out_tok);
    assign o_occupancy = r_out_occ;
    assign o_last      = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("fill count beyond depth");

    a_list_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |=> o_valid)
        else $error("list cycle without a result");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_occupancy == '0))
        else $error("empty status with nonzero occupancy");

    a_pop_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cmd_valid) |=> (r_state == S_EXEC))
        else $error("popped request not executed");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EXEC) |=> (r_count == $past(r_count)))
        else $error("fill count moved outside execution");

endmodule
